FILE: hdl/rhef_pkg.sv
package rhef_pkg;

	// event store geometry
	localparam int QUEUE_DEPTH  = 256;
	localparam int IDX_W        = $clog2(QUEUE_DEPTH);
	localparam int FILL_W       = IDX_W + 1;
	localparam int PAYLOAD_BITS = 64;
	localparam int TOTAL_W      = 32;

	// command queue between front and back, depth a power of two
	localparam int CQ_DEPTH = 4;
	localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
	localparam int CQ_CNT_W = CQ_PTR_W + 1;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_RESERVE  = CFG_IDX_W'(1);
	localparam logic [CFG_DATA_W-1:0] CAPACITY_RESET = CFG_DATA_W'(256);
	localparam logic [CFG_DATA_W-1:0] RESERVE_RESET  = CFG_DATA_W'(0);

	// command codes
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	typedef struct packed {
		logic                    command;
		logic                    push_is_priority;
		logic [PAYLOAD_BITS-1:0] push_payload;
	} in_item_t;

	typedef struct packed {
		logic                    push_accepted;
		logic                    pop_empty;
		logic [PAYLOAD_BITS-1:0] pop_payload;
		logic                    pop_is_priority;
		logic [FILL_W-1:0]       occupancy;
		logic [TOTAL_W-1:0]      accepted_priority_count;
		logic [TOTAL_W-1:0]      accepted_ordinary_count;
		logic [TOTAL_W-1:0]      dropped_priority_count;
		logic [TOTAL_W-1:0]      dropped_ordinary_count;
	} out_item_t;

	// one classified command for the back end
	typedef struct packed {
		logic                    wr_en;
		logic                    rd_en;
		logic [IDX_W-1:0]        idx;
		logic                    wr_prio;
		logic [PAYLOAD_BITS-1:0] wr_payload;
		out_item_t               result;
	} cmd_t;

endpackage

FILE: hdl/reserved_headroom_event_fifo_unit.sv
// each result passes the command queue and the result register, delayed only by output stall;
// throughput: one command per cycle while the output is not stalled, set by the front decision
// path and the 4-entry command queue feeding the single-port event store and output register
// reset: pointers, fill count, totals and handshake state clear; capacity resets to 256,
// reserve to 0; the event store is not cleared, there is no clearing pass
module reserved_headroom_event_fifo_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rhef_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rhef_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  rhef_pkg::in_item_t               in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output rhef_pkg::out_item_t              out_data
);
	import rhef_pkg::*;

	logic cq_wr_valid;
	logic cq_wr_ready;
	cmd_t cq_wr_data;
	logic cq_rd_valid;
	logic cq_rd_ready;
	cmd_t cq_rd_data;

	// admission and pointer bookkeeping
	rhef_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cmd_valid (cq_wr_valid),
		.cmd_ready (cq_wr_ready),
		.cmd_data  (cq_wr_data)
	);

	// decoupling queue
	rhef_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cq_wr_valid),
		.wr_ready (cq_wr_ready),
		.wr_data  (cq_wr_data),
		.rd_valid (cq_rd_valid),
		.rd_ready (cq_rd_ready),
		.rd_data  (cq_rd_data)
	);

	// event store and result output
	rhef_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cq_rd_valid),
		.cmd_ready (cq_rd_ready),
		.cmd_data  (cq_rd_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

FILE: hdl/rhef_front.sv
module rhef_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rhef_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rhef_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  rhef_pkg::in_item_t               in_data,
	output logic                             cmd_valid,
	input  logic                             cmd_ready,
	output rhef_pkg::cmd_t                   cmd_data
);
	import rhef_pkg::*;

	logic [CFG_DATA_W-1:0] capacity_q;
	logic [CFG_DATA_W-1:0] reserve_q;
	logic [IDX_W-1:0]      head_q;
	logic [IDX_W-1:0]      tail_q;
	logic [FILL_W-1:0]     fill_q;
	logic [TOTAL_W-1:0]    acc_prio_q;
	logic [TOTAL_W-1:0]    acc_ord_q;
	logic [TOTAL_W-1:0]    drop_prio_q;
	logic [TOTAL_W-1:0]    drop_ord_q;

	logic [CFG_DATA_W-1:0] cap_eff;
	logic [CFG_DATA_W-1:0] res_eff;
	logic [CFG_DATA_W-1:0] limit;
	logic                  is_push;
	logic                  admit;
	logic                  pop_hit;
	logic                  xfer;

	logic [IDX_W-1:0]      head_d;
	logic [IDX_W-1:0]      tail_d;
	logic [FILL_W-1:0]     fill_d;
	logic [TOTAL_W-1:0]    acc_prio_d;
	logic [TOTAL_W-1:0]    acc_ord_d;
	logic [TOTAL_W-1:0]    drop_prio_d;
	logic [TOTAL_W-1:0]    drop_ord_d;

	function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
		return (v == '1) ? v : v + TOTAL_W'(1);
	endfunction

	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + IDX_W'(1);
	endfunction

	assign cfg_ready = 1'b1;
	assign in_ready  = cmd_ready;
	assign cmd_valid = in_valid;
	assign xfer      = in_valid && in_ready;

	// admission limit with capacity and reserve clamped
	always_comb begin
		cap_eff = (capacity_q > CFG_DATA_W'(QUEUE_DEPTH)) ? CFG_DATA_W'(QUEUE_DEPTH)
			: capacity_q;
		res_eff = (reserve_q > cap_eff) ? cap_eff : reserve_q;
		limit   = in_data.push_is_priority ? cap_eff : cap_eff - res_eff;
		is_push = (in_data.command == CMD_PUSH);
		admit   = is_push && (CFG_DATA_W'(fill_q) < limit);
		pop_hit = !is_push && (fill_q != '0);
	end

	// next queue state and totals
	always_comb begin
		head_d      = head_q;
		tail_d      = tail_q;
		fill_d      = fill_q;
		acc_prio_d  = acc_prio_q;
		acc_ord_d   = acc_ord_q;
		drop_prio_d = drop_prio_q;
		drop_ord_d  = drop_ord_q;
		if (admit) begin
			tail_d = next_idx(tail_q);
			fill_d = fill_q + FILL_W'(1);
			if (in_data.push_is_priority) begin
				acc_prio_d = sat_inc(acc_prio_q);
			end else begin
				acc_ord_d = sat_inc(acc_ord_q);
			end
		end else if (is_push) begin
			if (in_data.push_is_priority) begin
				drop_prio_d = sat_inc(drop_prio_q);
			end else begin
				drop_ord_d = sat_inc(drop_ord_q);
			end
		end
		if (pop_hit) begin
			head_d = next_idx(head_q);
			fill_d = fill_q - FILL_W'(1);
		end
	end

	// command handed to the back end
	always_comb begin
		cmd_data.wr_en      = admit;
		cmd_data.rd_en      = pop_hit;
		cmd_data.idx        = is_push ? tail_q : head_q;
		cmd_data.wr_prio    = in_data.push_is_priority;
		cmd_data.wr_payload = in_data.push_payload;
		cmd_data.result.push_accepted           = admit;
		cmd_data.result.pop_empty               = !is_push && (fill_q == '0);
		cmd_data.result.pop_payload             = '0;
		cmd_data.result.pop_is_priority         = 1'b0;
		cmd_data.result.occupancy               = fill_d;
		cmd_data.result.accepted_priority_count = acc_prio_d;
		cmd_data.result.accepted_ordinary_count = acc_ord_d;
		cmd_data.result.dropped_priority_count  = drop_prio_d;
		cmd_data.result.dropped_ordinary_count  = drop_ord_d;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
			reserve_q  <= RESERVE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CAPACITY: capacity_q <= cfg_data;
				REG_RESERVE:  reserve_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// queue pointers and totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			fill_q      <= '0;
			acc_prio_q  <= '0;
			acc_ord_q   <= '0;
			drop_prio_q <= '0;
			drop_ord_q  <= '0;
		end else if (xfer) begin
			head_q      <= head_d;
			tail_q      <= tail_d;
			fill_q      <= fill_d;
			acc_prio_q  <= acc_prio_d;
			acc_ord_q   <= acc_ord_d;
			drop_prio_q <= drop_prio_d;
			drop_ord_q  <= drop_ord_d;
		end
	end

endmodule

FILE: hdl/rhef_queue.sv
module rhef_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  rhef_pkg::cmd_t wr_data,
	output logic           rd_valid,
	input  logic           rd_ready,
	output rhef_pkg::cmd_t rd_data
);
	import rhef_pkg::*;

	cmd_t                ent_q [CQ_DEPTH];
	logic [CQ_PTR_W-1:0] wr_ptr_q;
	logic [CQ_PTR_W-1:0] rd_ptr_q;
	logic [CQ_CNT_W-1:0] count_q;
	logic                push;
	logic                pop;

	assign wr_ready = (count_q != CQ_CNT_W'(CQ_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = ent_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers wrap naturally, depth is a power of two
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + CQ_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + CQ_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CQ_CNT_W'(1);
				2'b01:   count_q <= count_q - CQ_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: hdl/rhef_back.sv
module rhef_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  rhef_pkg::cmd_t        cmd_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output rhef_pkg::out_item_t   out_data
);
	import rhef_pkg::*;

	logic [PAYLOAD_BITS:0] mem_q [QUEUE_DEPTH];
	logic [PAYLOAD_BITS:0] rd_q;
	out_item_t             res_s1;
	logic                  hit_s1;
	logic                  valid_q;
	logic                  advance;

	assign cmd_ready = !valid_q || out_ready;
	assign advance   = cmd_valid && cmd_ready;
	assign out_valid = valid_q;

	// event store: write on accepted push, registered read on pop
	always_ff @(posedge clk) begin
		if (advance && cmd_data.wr_en) begin
			mem_q[cmd_data.idx] <= {cmd_data.wr_prio, cmd_data.wr_payload};
		end
		if (advance && cmd_data.rd_en) begin
			rd_q <= mem_q[cmd_data.idx];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (advance) begin
			res_s1 <= cmd_data.result;
			hit_s1 <= cmd_data.rd_en;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd_ready) begin
			valid_q <= cmd_valid;
		end
	end

	// merge popped event into the result
	always_comb begin
		out_data                 = res_s1;
		out_data.pop_payload     = hit_s1 ? rd_q[PAYLOAD_BITS-1:0] : '0;
		out_data.pop_is_priority = hit_s1 ? rd_q[PAYLOAD_BITS] : 1'b0;
	end

endmodule

FILE: hdl/rhef_checker.sv
module rhef_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_ready,
	input rhef_pkg::out_item_t   out_data
);
	import rhef_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// a result is never both an accepted push and an empty pop
	a_kind_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.push_accepted && out_data.pop_empty))
		else $error("push accept and pop empty together");

	// an empty pop leaves nothing queued and carries no event
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.pop_empty |->
			out_data.occupancy == '0 && out_data.pop_payload == '0
			&& !out_data.pop_is_priority)
		else $error("empty pop with data or occupancy");

	// an accepted push leaves at least one event queued
	a_push_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.push_accepted |->
			out_data.occupancy != '0 && out_data.pop_payload == '0)
		else $error("accepted push with zero occupancy");

endmodule

bind reserved_headroom_event_fifo_unit rhef_checker u_rhef_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
